### rtl/ldf_pkg.sv
// Shared types and constants for the lidar packet deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ldf_pkg;

    localparam int unsigned NumReadings = 4;
    localparam int unsigned SlotW       = $clog2(NumReadings);
    localparam int unsigned WordW       = 16;
    localparam int unsigned AccW        = 27;
    localparam int unsigned ChkW        = 15;
    localparam int unsigned PosW        = 5;

    localparam logic [7:0] StartByte = 8'hFA;
    localparam logic [7:0] IndexLow  = 8'hA0;
    localparam logic [7:0] IndexHigh = 8'hF9;

    localparam logic [PosW-1:0] PosFirst = 5'd2;
    localparam logic [PosW-1:0] PosChk   = 5'd21;
    localparam logic [PosW-1:0] PosRd0   = 5'd5;
    localparam logic [PosW-1:0] PosRd1   = 5'd9;
    localparam logic [PosW-1:0] PosRd2   = 5'd13;
    localparam logic [PosW-1:0] PosRd3   = 5'd17;

    localparam logic [1:0] QualGood    = 2'd0;
    localparam logic [1:0] QualInvalid = 2'd1;
    localparam logic [1:0] QualWarning = 2'd2;

    localparam logic [12:0] DistInvalid = 13'd7000;
    localparam logic [12:0] DistWarning = 13'd8000;

    // Packet with a good checksum, handed from the parser to the emitter.
    typedef struct packed {
        logic                 valid;
        logic [7:0]           index;
        logic [WordW-1:0]     word0;
        logic [WordW-1:0]     word1;
        logic [WordW-1:0]     word2;
        logic [WordW-1:0]     word3;
    } pkt_t;

endpackage

### rtl/ldf_parser.sv
// Byte-level frame parser: start/index hunt, word assembly and checksum.
// Depends on ldf_pkg; feeds ldf_emitter through an ldf_pkg::pkt_t.
`timescale 1ns / 1ps

module ldf_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          byte_valid,
    input  logic [7:0]    byte_data,
    input  logic          emit_busy,
    output logic          byte_ready,
    output ldf_pkg::pkt_t pkt
);
    import ldf_pkg::*;

    typedef enum logic [1:0] {
        HUNT,
        WAIT_INDEX,
        COLLECT
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [PosW-1:0]     pos_reg, pos_next;
    logic [AccW-1:0]     acc_reg, acc_next;
    logic [7:0]          low_reg, low_next;
    logic [7:0]          index_reg, index_next;
    logic [WordW-1:0]    words_reg [NumReadings];

    logic                accept;
    logic [WordW-1:0]    word;
    logic [ChkW-1:0]     folded;
    logic                at_chk;
    logic                word_step;

    assign at_chk     = (phase_reg == COLLECT) && (pos_reg == PosChk);
    // Stall only the checksum byte while the previous packet still drains.
    assign byte_ready = !(at_chk && emit_busy);
    assign accept     = byte_valid && byte_ready;
    assign word       = {byte_data, low_reg};
    assign folded     = ChkW'(acc_reg[ChkW-1:0] + ChkW'(acc_reg[AccW-1:ChkW]));
    assign word_step  = accept && (phase_reg == COLLECT) && pos_reg[0] && !at_chk;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        low_next   = low_reg;
        index_next = index_reg;
        pkt        = '0;
        pkt.index  = index_reg;
        pkt.word0  = words_reg[0];
        pkt.word1  = words_reg[1];
        pkt.word2  = words_reg[2];
        pkt.word3  = words_reg[3];
        if (accept) begin
            unique case (phase_reg)
                WAIT_INDEX: begin
                    if (byte_data >= IndexLow && byte_data <= IndexHigh) begin
                        index_next = byte_data;
                        acc_next   = AccW'({byte_data, StartByte});
                        pos_next   = PosFirst;
                        phase_next = COLLECT;
                    end else if (byte_data != StartByte) begin
                        phase_next = HUNT;
                    end
                end
                COLLECT: begin
                    if (!pos_reg[0]) begin
                        low_next = byte_data;
                        pos_next = pos_reg + 1'b1;
                    end else if (!at_chk) begin
                        acc_next = AccW'({acc_reg, 1'b0}) + AccW'(word);
                        pos_next = pos_reg + 1'b1;
                    end else begin
                        phase_next = HUNT;
                        pos_next   = '0;
                        pkt.valid  = (word == {1'b0, folded});
                    end
                end
                default: begin
                    phase_next = (byte_data == StartByte) ? WAIT_INDEX : HUNT;
                    pos_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= HUNT;
            pos_reg   <= '0;
            acc_reg   <= '0;
            low_reg   <= '0;
            index_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            low_reg   <= low_next;
            index_reg <= index_next;
        end
    end

    // Reading words are always written before the packet can complete.
    always_ff @(posedge aclk) begin
        if (word_step) begin
            if (pos_reg == PosRd0) words_reg[0] <= word;
            if (pos_reg == PosRd1) words_reg[1] <= word;
            if (pos_reg == PosRd2) words_reg[2] <= word;
            if (pos_reg == PosRd3) words_reg[3] <= word;
        end
    end

endmodule

### rtl/ldf_emitter.sv
// Reading emitter: holds a good packet and issues four decoded readings.
// Depends on ldf_pkg; driven by ldf_parser.
`timescale 1ns / 1ps

module ldf_emitter (
    input  logic          aclk,
    input  logic          aresetn,
    input  ldf_pkg::pkt_t pkt,
    output logic          emit_busy,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_index,
    output logic [8:0]    out_angle,
    output logic [12:0]   out_distance,
    output logic [1:0]    out_quality,
    output logic          out_last
);
    import ldf_pkg::*;

    logic [WordW-1:0]  hold_words_reg [NumReadings];
    logic [7:0]        hold_index_reg;
    logic              pend_reg;
    logic [SlotW-1:0]  slot_reg;

    logic              valid_reg;
    logic [7:0]        index_reg;
    logic [8:0]        angle_reg;
    logic [12:0]       dist_reg;
    logic [1:0]        qual_reg;
    logic              last_reg;

    logic              load_out;
    logic [WordW-1:0]  cur_word;
    logic [29:0]       recip_prod;
    logic [12:0]       dist_next;
    logic [1:0]        qual_next;
    logic [8:0]        angle_next;

    assign emit_busy = pend_reg;
    assign load_out  = pend_reg && (!valid_reg || out_ready);
    assign cur_word  = hold_words_reg[slot_reg];

    // x / 10 for a 14-bit x: multiply by ceil(2^19 / 10) and shift.
    assign recip_prod = 30'(cur_word[13:0]) * 30'd52429;

    always_comb begin
        priority if (cur_word[15]) begin
            dist_next = DistInvalid;
            qual_next = QualInvalid;
        end else if (cur_word[14]) begin
            dist_next = DistWarning;
            qual_next = QualWarning;
        end else begin
            dist_next = 13'(recip_prod[29:19]);
            qual_next = QualGood;
        end
    end

    assign angle_next = 9'({9'(hold_index_reg) - 9'd160, 2'b00}) + 9'(slot_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= 1'b0;
            slot_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (pkt.valid) begin
                pend_reg <= 1'b1;
                slot_reg <= '0;
            end else if (load_out) begin
                slot_reg <= slot_reg + 1'b1;
                if (slot_reg == SlotW'(NumReadings - 1)) pend_reg <= 1'b0;
            end
            if (load_out) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pkt.valid) begin
            hold_index_reg    <= pkt.index;
            hold_words_reg[0] <= pkt.word0;
            hold_words_reg[1] <= pkt.word1;
            hold_words_reg[2] <= pkt.word2;
            hold_words_reg[3] <= pkt.word3;
        end
        if (load_out) begin
            index_reg <= hold_index_reg;
            angle_reg <= angle_next;
            dist_reg  <= dist_next;
            qual_reg  <= qual_next;
            last_reg  <= (slot_reg == SlotW'(NumReadings - 1));
        end
    end

    assign out_valid    = valid_reg;
    assign out_index    = index_reg;
    assign out_angle    = angle_reg;
    assign out_distance = dist_reg;
    assign out_quality  = qual_reg;
    assign out_last     = last_reg;

endmodule

### rtl/lidar_packet_deframer.sv
// Top level of the lidar 22-byte packet deframer.
// Depends on ldf_pkg, ldf_parser and ldf_emitter.
//
//   channel   dir  tdata fields (low bit up)                        side band
//   s_*       in   byte_in[7:0]                                     -
//   m_*       out  packet_index[7:0] angle_deg[16:8] distance[29:17] tuser=quality, tlast=last
//
// One byte is taken per cycle while s_tready is high; the parser state updates at the transfer.
// A packet with a good checksum yields four readings, one per cycle while m_tready is high,
// from the emitter's hold registers through the output register.
// Synchronous active-low reset returns the parser to hunting for 0xFA.
// s_tready drops only on a checksum byte while the emitter still holds readings of the
// previous packet that have not yet been loaded into the output register.
`timescale 1ns / 1ps

module lidar_packet_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_in[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // packet_index[7:0], angle_deg[16:8], distance[29:17]
    output logic [1:0]  m_tuser,   // quality[1:0]
    output logic        m_tlast
);
    import ldf_pkg::*;

    pkt_t        pkt;
    logic        emit_busy;
    logic [7:0]  out_index;
    logic [8:0]  out_angle;
    logic [12:0] out_distance;

    ldf_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid),
        .byte_data  (s_tdata),
        .emit_busy  (emit_busy),
        .byte_ready (s_tready),
        .pkt        (pkt)
    );

    ldf_emitter u_emitter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pkt          (pkt),
        .emit_busy    (emit_busy),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_index    (out_index),
        .out_angle    (out_angle),
        .out_distance (out_distance),
        .out_quality  (m_tuser),
        .out_last     (m_tlast)
    );

    assign m_tdata = {2'b00, out_distance, out_angle, out_index};

endmodule

### bench/ldf_scoreboard_pkg.sv
// Reading predictor and scoreboard for the lidar packet deframer bench.
// Depends on ldf_pkg for widths, framing bytes and quality/distance codes.
`timescale 1ns / 1ps

package ldf_scoreboard_pkg;

    import ldf_pkg::*;

    typedef enum logic [1:0] {
        PhaseHunt,
        PhaseIndex,
        PhaseCollect
    } frame_phase_t;

    typedef struct packed {
        logic [7:0]  index;
        logic [8:0]  angle;
        logic [12:0] distance;
        logic [1:0]  qual;
        logic        last;
    } reading_t;

    class reading_scoreboard;

        frame_phase_t     phase;
        logic [PosW-1:0]  pos;
        logic [AccW-1:0]  acc;
        logic [7:0]       low_byte;
        logic [7:0]       index_hold;
        logic [WordW-1:0] words [NumReadings];

        reading_t    expected_readings [$];
        int unsigned errors;
        int unsigned readings_checked;
        int unsigned good_packets;
        int unsigned dropped_packets;

        function new();
            phase            = PhaseHunt;
            pos              = '0;
            acc              = '0;
            low_byte         = '0;
            index_hold       = '0;
            errors           = 0;
            readings_checked = 0;
            good_packets     = 0;
            dropped_packets  = 0;
        endfunction

        // Fold the running sum to 15 bits.
        static function logic [ChkW-1:0] fold(logic [AccW-1:0] sum);
            logic [15:0] folded;
            folded = 16'(sum[ChkW-1:0]) + 16'(sum[AccW-1:ChkW]);
            return folded[ChkW-1:0];
        endfunction

        function int unsigned pending();
            return expected_readings.size();
        endfunction

        function void push_readings();
            reading_t         r;
            logic [WordW-1:0] w;
            for (int s = 0; s < NumReadings; s++) begin
                w       = words[s];
                r.index = index_hold;
                r.angle = 9'((int'(index_hold) - 160) * 4 + s);
                r.last  = (s == NumReadings - 1);
                if (w[15]) begin
                    r.distance = DistInvalid;
                    r.qual     = QualInvalid;
                end else if (w[14]) begin
                    r.distance = DistWarning;
                    r.qual     = QualWarning;
                end else begin
                    r.distance = 13'(w[13:0] / 14'd10);
                    r.qual     = QualGood;
                end
                expected_readings.push_back(r);
            end
        endfunction

        // Advance the frame parser by one accepted byte.
        function void note_byte(logic [7:0] b);
            logic [WordW-1:0] word;
            case (phase)
                PhaseIndex: begin
                    if (b >= IndexLow && b <= IndexHigh) begin
                        index_hold = b;
                        acc        = {11'd0, b, StartByte};
                        pos        = PosFirst;
                        phase      = PhaseCollect;
                    end else if (b != StartByte) begin
                        phase = PhaseHunt;
                    end
                end
                PhaseCollect: begin
                    if (!pos[0]) begin
                        low_byte = b;
                        pos      = pos + 1'b1;
                    end else begin
                        word = {b, low_byte};
                        if (pos < PosChk) begin
                            acc = (acc << 1) + AccW'(word);
                            case (pos)
                                PosRd0: words[0] = word;
                                PosRd1: words[1] = word;
                                PosRd2: words[2] = word;
                                PosRd3: words[3] = word;
                                default: ;
                            endcase
                            pos = pos + 1'b1;
                        end else begin
                            phase = PhaseHunt;
                            pos   = '0;
                            if (word == {1'b0, fold(acc)}) begin
                                good_packets++;
                                push_readings();
                            end else begin
                                dropped_packets++;
                            end
                        end
                    end
                end
                default: begin
                    phase = (b == StartByte) ? PhaseIndex : PhaseHunt;
                    pos   = '0;
                end
            endcase
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_reading(logic [31:0] tdata, logic [1:0] tuser, logic tlast);
            reading_t want;
            if (expected_readings.size() == 0) begin
                $error("reading with none expected: tdata=%h tuser=%0d tlast=%0b",
                       tdata, tuser, tlast);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            readings_checked++;
            compare_field("packet_index", want.index,    tdata[7:0]);
            compare_field("angle_deg",    want.angle,    tdata[16:8]);
            compare_field("distance",     want.distance, tdata[29:17]);
            compare_field("quality",      want.qual,     tuser);
            compare_field("last",         want.last,     tlast);
        endfunction

    endclass

endpackage

### bench/testbench.sv
// Self-checking bench for lidar_packet_deframer: byte stream in, readings out.
// Depends on ldf_pkg, ldf_scoreboard_pkg and the deframer RTL.
`timescale 1ns / 1ps

module testbench;

    import ldf_pkg::*;
    import ldf_scoreboard_pkg::*;

    typedef enum int {
        ChkIntact,
        ChkFlipped,
        ChkBit15
    } chk_fault_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    reading_scoreboard sb;
    int unsigned       burst_left = 0;
    int unsigned       bytes_sent = 0;
    int unsigned       stall_left = 0;
    int unsigned       stall_mode = 0;
    int unsigned       mode_left  = 0;

    lidar_packet_deframer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: always ready, random stalls, or rare long stalls, switching now and then.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(4, 16);
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_reading(m_tdata, m_tuser, m_tlast);
    end

    // Hold one byte on the bus until its transfer; open a random gap between bursts.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_readings_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Frame: start, index, speed word, four readings of distance and signal words,
    // checksum word.
    task automatic send_packet(input logic [7:0] idx, input logic [3:0][15:0] rd,
                               input chk_fault_t fault, input int unsigned extra_starts);
        logic [7:0]      pkt [22];
        logic [AccW-1:0] sum;
        logic [15:0]     chk;
        pkt[0] = StartByte;
        pkt[1] = idx;
        for (int i = 2; i < 20; i++) pkt[i] = 8'($urandom);
        for (int r = 0; r < 4; r++) begin
            pkt[4 + 4 * r] = rd[r][7:0];
            pkt[5 + 4 * r] = rd[r][15:8];
        end
        sum = '0;
        for (int i = 0; i < 10; i++) sum = (sum << 1) + AccW'({pkt[2 * i + 1], pkt[2 * i]});
        chk = {1'b0, reading_scoreboard::fold(sum)};
        case (fault)
            ChkFlipped: chk = chk ^ 16'($urandom_range(1, 16'h7FFF));
            ChkBit15:   chk = chk | 16'h8000;
            default: ;
        endcase
        pkt[20] = chk[7:0];
        pkt[21] = chk[15:8];
        repeat (extra_starts) send_byte(StartByte);
        for (int i = 0; i < 22; i++) send_byte(pkt[i]);
    endtask

    function automatic logic [15:0] random_reading_word();
        case ($urandom_range(0, 5))
            0: return {1'b1, 15'($urandom)};
            1: return {2'b01, 14'($urandom)};
            2: return ($urandom_range(0, 1) != 0) ? 16'h3FFF : 16'h0000;
            default: return {2'b00, 14'($urandom)};
        endcase
    endfunction

    initial begin
        int unsigned      random_bytes;
        logic [3:0][15:0] rd;
        logic [7:0]       idx;
        chk_fault_t       fault;

        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Noise, start byte followed by out-of-range index bytes, repeated start bytes.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(StartByte);
        send_byte(8'h9F);
        send_byte(StartByte);
        send_byte(8'hFB);
        send_packet(IndexLow, {16'h3FFF, 16'h0000, 16'h4000, 16'h8ABC}, ChkIntact, 2);
        send_packet(IndexHigh, {16'h7FFF, 16'h3FF9, 16'hC123, 16'hFAFA}, ChkIntact, 0);
        send_packet(8'hB7, {16'h1234, 16'h0FFF, 16'h2000, 16'h0001}, ChkFlipped, 0);
        send_packet(8'hC8, {16'h0100, 16'h0200, 16'h0300, 16'h0400}, ChkBit15, 0);
        wait_readings_drained();

        random_bytes = 0;
        while (random_bytes < 155) begin
            if (bytes_sent > 120 && bytes_sent < 140 && sb.pending() != 0)
                wait_readings_drained();
            case ($urandom_range(0, 9))
                0: begin
                    send_byte(8'($urandom));
                    random_bytes += 1;
                end
                1: begin
                    // start byte, then an index outside the accepted range
                    send_byte(StartByte);
                    send_byte(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 159))
                                                          : 8'($urandom_range(251, 255)));
                    random_bytes += 2;
                end
                2: begin
                    // cut-short packet: the parser swallows what follows as data
                    idx = 8'($urandom_range(IndexLow, IndexHigh));
                    send_byte(StartByte);
                    send_byte(idx);
                    random_bytes += 2;
                    repeat ($urandom_range(0, 19)) begin
                        send_byte(8'($urandom));
                        random_bytes += 1;
                    end
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0: idx = IndexLow;
                        1: idx = IndexHigh;
                        default: idx = 8'($urandom_range(IndexLow, IndexHigh));
                    endcase
                    for (int r = 0; r < 4; r++) rd[r] = random_reading_word();
                    case ($urandom_range(0, 9))
                        0: fault = ChkFlipped;
                        1: fault = ChkBit15;
                        default: fault = ChkIntact;
                    endcase
                    send_packet(idx, rd, fault, ($urandom_range(0, 4) == 0) ? 1 : 0);
                    random_bytes += 22;
                end
            endcase
        end

        wait_readings_drained();
        repeat (30) @(posedge aclk);

        $display("Sent %0d bytes: %0d packets with good checksum, %0d dropped on mismatch.",
                 bytes_sent, sb.good_packets, sb.dropped_packets);
        $display("Checked %0d readings, %0d mismatches.", sb.readings_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS lidar_packet_deframer");
        end else begin
            $display("FAIL lidar_packet_deframer");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Timeout with %0d readings outstanding.", sb.pending());
        $display("FAIL lidar_packet_deframer");
        $finish;
    end

endmodule
